FILE: src/vtx_pkg.sv
// Shared types and constants of the videotex line-side command handler.
// Depends on nothing; the front end, queue, back end, top level and checker use it by scoped names.
package vtx_pkg;

  // Most results that the list of one received byte can hold.
  localparam int unsigned MaxRes = 6;

  // Result channel codes.
  localparam logic [1:0] ChScreen = 2'd0;
  localparam logic [1:0] ChModem  = 2'd1;
  localparam logic [1:0] ChEvent  = 2'd2;

  // Screen event codes.
  localparam logic [7:0] Ev40Col   = 8'd0;
  localparam logic [7:0] Ev80Col   = 8'd1;
  localparam logic [7:0] EvRollOff = 8'd2;
  localparam logic [7:0] EvRollOn  = 8'd3;
  localparam logic [7:0] EvReset   = 8'd4;

  // Keyboard modes.
  localparam logic [2:0] KbTeletel = 3'd0;
  localparam logic [2:0] KbExt     = 3'd1;
  localparam logic [2:0] KbC0      = 3'd2;
  localparam logic [2:0] KbMixUs   = 3'd4;
  localparam logic [2:0] KbInfoUs  = 3'd6;

  // Protocol bytes.
  localparam logic [7:0] ByteEsc    = 8'h1b;
  localparam logic [7:0] BytePro1   = 8'h39;
  localparam logic [7:0] BytePro2   = 8'h3a;
  localparam logic [7:0] BytePro3   = 8'h3b;
  localparam logic [7:0] ByteCursor = 8'h61;
  localparam logic [7:0] ByteSep    = 8'h13;
  localparam logic [7:0] ByteUs     = 8'h1f;
  localparam logic [7:0] ByteCr     = 8'h0d;

  // One decoded item: its results and the modes after it.
  typedef struct packed {
    logic [2:0]            n;
    logic [MaxRes-1:0][1:0] ch;
    logic [MaxRes-1:0][7:0] dat;
    logic [2:0]            kbd;
    logic                  wide;
    logic                  roll;
  } job_t;

endpackage

FILE: src/vtx_in_if.sv
// Input channel of the videotex command handler: received byte and cursor.
// Depends on nothing.
interface vtx_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;
  logic [7:0] cursor_row;
  logic [7:0] cursor_col;

  modport source (output valid, cmd, rx_byte, cursor_row, cursor_col, input ready);
  modport sink   (input valid, cmd, rx_byte, cursor_row, cursor_col, output ready);
endinterface

FILE: src/vtx_out_if.sv
// Result channel of the videotex command handler.
// Depends on nothing.
interface vtx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] channel;
  logic [7:0] data;
  logic [2:0] keyboard_mode;
  logic       wide_screen;
  logic       roll_on;
  logic       last;

  modport source (output valid, channel, data, keyboard_mode, wide_screen, roll_on, last,
                  input ready);
  modport sink   (input valid, channel, data, keyboard_mode, wide_screen, roll_on, last,
                  output ready);
endinterface

FILE: src/vtx_cfg_if.sv
// Configuration write channel of the videotex command handler.
// Depends on nothing.
interface vtx_cfg_if;
  logic valid;
  logic ready;
  logic compat_x3;

  modport source (output valid, compat_x3, input ready);
  modport sink   (input valid, compat_x3, output ready);
endinterface

FILE: src/vtx_front.sv
// Front end: parses received bytes, keeps the protocol state and modes,
// and builds one result list per item. Depends on vtx_pkg.
module vtx_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              compat_x3_i,
  input  logic              in_fire_i,
  input  logic              cmd_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        cursor_row_i,
  input  logic [7:0]        cursor_col_i,
  output vtx_pkg::job_t     job_o,
  output logic              push_o
);

  typedef enum logic [10:0] {
    StNormal  = 11'b000_0000_0001,
    StEsc     = 11'b000_0000_0010,
    StPro1    = 11'b000_0000_0100,
    StPro2A   = 11'b000_0000_1000,
    StPro2B   = 11'b000_0001_0000,
    StPro3A   = 11'b000_0010_0000,
    StPro3B   = 11'b000_0100_0000,
    StPro3C   = 11'b000_1000_0000,
    StCursor  = 11'b001_0000_0000,
    StTransp  = 11'b010_0000_0000,
    StInhibit = 11'b100_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] first_arg_q, first_arg_d;
  logic [7:0] second_arg_q, second_arg_d;
  logic [7:0] left_q, left_d;
  logic [2:0] kbd_q, kbd_d;
  logic       scr_q, scr_d;
  logic       roll_q, roll_d;
  vtx_pkg::job_t job;

  // Append one result to the list.
  function automatic vtx_pkg::job_t push(vtx_pkg::job_t j, logic [1:0] ch, logic [7:0] d);
    vtx_pkg::job_t r;
    r = j;
    if (j.n < 3'(vtx_pkg::MaxRes)) begin
      r.ch[j.n]  = ch;
      r.dat[j.n] = d;
      r.n        = j.n + 3'd1;
    end
    return r;
  endfunction

  function automatic vtx_pkg::job_t modem(vtx_pkg::job_t j, logic [7:0] d);
    return push(j, vtx_pkg::ChModem, d);
  endfunction

  // Acknowledge in X3 escape form or in SEP form.
  function automatic vtx_pkg::job_t ack(vtx_pkg::job_t j, logic x3, logic [7:0] mid,
                                        logic [7:0] lst, logic [7:0] sep);
    vtx_pkg::job_t r;
    r = j;
    if (x3) begin
      r = modem(r, vtx_pkg::ByteEsc);
      r = modem(r, mid);
      r = modem(r, lst);
      r = modem(r, vtx_pkg::ByteCr);
    end else begin
      r = modem(r, vtx_pkg::ByteSep);
      r = modem(r, sep);
    end
    return r;
  endfunction

  function automatic vtx_pkg::job_t status_pro2(vtx_pkg::job_t j, logic roll, logic scr);
    vtx_pkg::job_t r;
    r = modem(j, vtx_pkg::ByteEsc);
    r = modem(r, vtx_pkg::BytePro2);
    r = modem(r, 8'h73);
    r = modem(r, {6'b010000, roll, scr});
    return r;
  endfunction

  function automatic vtx_pkg::job_t status_kbd(vtx_pkg::job_t j, logic [2:0] kbd);
    vtx_pkg::job_t r;
    logic [7:0]    s;
    s = 8'h40;
    if (kbd == vtx_pkg::KbExt) s = 8'h41;
    if (kbd == vtx_pkg::KbC0) s = 8'h44;
    r = modem(j, vtx_pkg::ByteEsc);
    r = modem(r, vtx_pkg::BytePro3);
    r = modem(r, 8'h73);
    r = modem(r, 8'h59);
    r = modem(r, s);
    return r;
  endfunction

  // Next state and result list of the offered item.
  always_comb begin
    logic [7:0] c;
    logic [7:0] a;
    logic [7:0] b;
    c            = rx_byte_i;
    a            = first_arg_q;
    b            = second_arg_q;
    state_d      = state_q;
    first_arg_d  = first_arg_q;
    second_arg_d = second_arg_q;
    left_d       = left_q;
    kbd_d        = kbd_q;
    scr_d        = scr_q;
    roll_d       = roll_q;
    job          = '0;
    if (cmd_i) begin
      // Return from 80 columns: internal reset, then SEP acknowledge.
      state_d = StNormal;
      kbd_d   = vtx_pkg::KbTeletel;
      scr_d   = 1'b0;
      roll_d  = 1'b0;
      job     = push(job, vtx_pkg::ChEvent, vtx_pkg::EvReset);
      job     = modem(job, vtx_pkg::ByteSep);
      job     = modem(job, 8'h5e);
    end else begin
      unique case (state_q)
        StNormal: begin
          if (c == vtx_pkg::ByteEsc) state_d = StEsc;
          else job = push(job, vtx_pkg::ChScreen, c);
        end
        StEsc: begin
          if (c == vtx_pkg::BytePro1) state_d = StPro1;
          else if (c == vtx_pkg::BytePro2) state_d = StPro2A;
          else if (c == vtx_pkg::BytePro3) state_d = StPro3A;
          else if (c == vtx_pkg::ByteCursor) state_d = StCursor;
          else begin
            state_d = StNormal;
            job     = push(job, vtx_pkg::ChScreen, vtx_pkg::ByteEsc);
            job     = push(job, vtx_pkg::ChScreen, c);
          end
        end
        StPro1: begin
          state_d = StNormal;
          case (c)
            8'h6c, 8'h6d: job = ack(job, compat_x3_i, 8'h21, 8'h35, 8'h51);
            8'h70: begin
              job = modem(job, vtx_pkg::ByteEsc);
              job = modem(job, vtx_pkg::BytePro2);
              job = modem(job, 8'h71);
              job = modem(job, 8'h4a);
            end
            8'h72: job = status_pro2(job, roll_q, scr_q);
            8'h74, 8'h76: begin
              job = modem(job, vtx_pkg::ByteEsc);
              job = modem(job, vtx_pkg::BytePro2);
              job = modem(job, c + 8'h01);
              job = modem(job, 8'h4f);
            end
            8'h7b: begin
              job = modem(job, 8'h01);
              job = modem(job, 8'h5a);
              job = modem(job, 8'h75);
              job = modem(job, 8'h31);
              job = modem(job, 8'h04);
            end
            8'h7f: begin
              kbd_d  = vtx_pkg::KbTeletel;
              scr_d  = 1'b0;
              roll_d = 1'b0;
              job    = push(job, vtx_pkg::ChEvent, vtx_pkg::EvReset);
              job    = ack(job, compat_x3_i, 8'h2e, 8'h35, 8'h5e);
            end
            default: ;
          endcase
        end
        StPro2A: begin
          state_d     = StPro2B;
          first_arg_d = c;
        end
        StPro2B: begin
          // The second argument is the current byte.
          state_d = StNormal;
          if (a == 8'h71 || a == 8'h73 || a == 8'h75 || a == 8'h77) begin
            // Reply codes are filtered.
          end else if (a == 8'h66) begin
            job     = ack(job, compat_x3_i, 8'h27, 8'h35, 8'h57);
            state_d = StTransp;
            left_d  = c;
          end else if ((a == 8'h69 || a == 8'h6a) && (c == 8'h44 || c == 8'h45)) begin
            job = status_pro2(job, roll_q, scr_q);
          end else if (a == 8'h72 && c == 8'h59) begin
            job = status_kbd(job, kbd_q);
          end else if (a == 8'h69 && c == 8'h43) begin
            roll_d = 1'b1;
            job    = push(job, vtx_pkg::ChEvent, vtx_pkg::EvRollOn);
            job    = status_pro2(job, 1'b1, scr_q);
          end else if (a == 8'h6a && c == 8'h43) begin
            roll_d = 1'b0;
            job    = push(job, vtx_pkg::ChEvent, vtx_pkg::EvRollOff);
            job    = status_pro2(job, 1'b0, scr_q);
          end else if (a == 8'h31 && c == 8'h7d) begin
            job     = modem(job, vtx_pkg::ByteEsc);
            job     = modem(job, 8'h5b);
            job     = modem(job, 8'h3f);
            job     = modem(job, 8'h7a);
            scr_d   = 1'b1;
            roll_d  = 1'b1;
            job     = push(job, vtx_pkg::ChEvent, vtx_pkg::Ev80Col);
            state_d = StInhibit;
            kbd_d   = vtx_pkg::KbInfoUs;
          end else if (a == 8'h32 && c == 8'h7d) begin
            job    = modem(job, vtx_pkg::ByteSep);
            job    = modem(job, 8'h70);
            scr_d  = 1'b1;
            roll_d = 1'b1;
            job    = push(job, vtx_pkg::ChEvent, vtx_pkg::Ev80Col);
            kbd_d  = vtx_pkg::KbMixUs;
          end else if (a == 8'h32 && c == 8'h7e) begin
            scr_d  = 1'b0;
            roll_d = 1'b0;
            job    = push(job, vtx_pkg::ChEvent, vtx_pkg::Ev40Col);
            kbd_d  = vtx_pkg::KbTeletel;
          end
        end
        StPro3A: begin
          state_d     = StPro3B;
          first_arg_d = c;
        end
        StPro3B: begin
          state_d      = StPro3C;
          second_arg_d = c;
        end
        StPro3C: begin
          state_d = StNormal;
          if (b == 8'h59) begin
            if (a == 8'h69 && c == 8'h41) begin
              if (kbd_q <= vtx_pkg::KbC0) kbd_d = vtx_pkg::KbExt;
              job = status_kbd(job, kbd_d);
            end else if (a == 8'h69 && c == 8'h43) begin
              if (kbd_q <= vtx_pkg::KbC0) kbd_d = vtx_pkg::KbC0;
              job = status_kbd(job, kbd_d);
            end else if (a == 8'h6a && c == 8'h41) begin
              if (kbd_q == vtx_pkg::KbC0 || kbd_q == vtx_pkg::KbExt) begin
                kbd_d = vtx_pkg::KbTeletel;
              end
              job = status_kbd(job, kbd_d);
            end else if (a == 8'h6a && c == 8'h43) begin
              if (kbd_q == vtx_pkg::KbC0) kbd_d = vtx_pkg::KbExt;
              job = status_kbd(job, kbd_d);
            end
          end
        end
        StCursor: begin
          state_d = StNormal;
          job     = modem(job, vtx_pkg::ByteUs);
          job     = modem(job, cursor_row_i);
          job     = modem(job, cursor_col_i);
        end
        StTransp: begin
          // Nonzero bytes count down; the mode ends once the count is zero.
          if (c != 8'h00 && left_q != 8'h00) left_d = left_q - 8'h01;
          if (left_d == 8'h00) state_d = StNormal;
        end
        StInhibit: begin
          job = push(job, vtx_pkg::ChScreen, c);
        end
        default: begin
          state_d = StNormal;
          job     = push(job, vtx_pkg::ChScreen, c);
        end
      endcase
    end
    job.kbd  = kbd_d;
    job.wide = scr_d;
    job.roll = roll_d;
  end

  // Protocol state and modes advance on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StNormal;
      first_arg_q  <= 8'h00;
      second_arg_q <= 8'h00;
      left_q       <= 8'h00;
      kbd_q        <= vtx_pkg::KbTeletel;
      scr_q        <= 1'b0;
      roll_q       <= 1'b0;
    end else if (in_fire_i) begin
      state_q      <= state_d;
      first_arg_q  <= first_arg_d;
      second_arg_q <= second_arg_d;
      left_q       <= left_d;
      kbd_q        <= kbd_d;
      scr_q        <= scr_d;
      roll_q       <= roll_d;
    end
  end

  // Items without results are not queued.
  assign job_o  = job;
  assign push_o = in_fire_i && (job.n != 3'd0);

endmodule

FILE: src/vtx_fifo.sv
// Short queue of decoded result lists between front end and back end.
// Depends on vtx_pkg.
module vtx_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vtx_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output vtx_pkg::job_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  vtx_pkg::job_t       entry_q [Depth];
  logic [PtrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = entry_q[rptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wptr_q] <= wdata_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (pop_i) rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: src/vtx_back.sv
// Back end: walks one queued result list and hands results out one per cycle
// while out_ready_i allows, through an output register. Depends on vtx_pkg.
module vtx_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  vtx_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    channel_o,
  output logic [7:0]    data_o,
  output logic [2:0]    kbd_o,
  output logic          wide_o,
  output logic          roll_o,
  output logic          last_o
);

  vtx_pkg::job_t job_q;
  logic          busy_q;
  logic [2:0]    idx_q;
  logic          out_valid_q;
  logic [1:0]    ch_q;
  logic [7:0]    dat_q;
  logic [2:0]    kbd_q;
  logic          wide_q, roll_q, last_q;
  logic          slot_free, emit, last_now, take;

  assign slot_free = !out_valid_q || out_ready_i;
  assign emit      = busy_q && slot_free;
  assign last_now  = (idx_q == job_q.n - 3'd1);
  assign take      = job_valid_i && (!busy_q || (emit && last_now));
  assign pop_o     = take;

  // Current list and position in it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else if (take) begin
      busy_q <= 1'b1;
      idx_q  <= 3'd0;
    end else if (emit) begin
      idx_q <= idx_q + 3'd1;
      if (last_now) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) job_q <= job_i;
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      ch_q   <= job_q.ch[idx_q];
      dat_q  <= job_q.dat[idx_q];
      kbd_q  <= job_q.kbd;
      wide_q <= job_q.wide;
      roll_q <= job_q.roll;
      last_q <= last_now;
    end
  end

  assign out_valid_o = out_valid_q;
  assign channel_o   = ch_q;
  assign data_o      = dat_q;
  assign kbd_o       = kbd_q;
  assign wide_o      = wide_q;
  assign roll_o      = roll_q;
  assign last_o      = last_q;

endmodule

FILE: src/videotex_protocol_command_handler.sv
// Top level of the videotex line-side command handler.
// Depends on vtx_pkg, the channel interfaces, vtx_front, vtx_fifo and vtx_back.

// Bytes from the modem line enter on in_if, one transfer per cycle while the
// result queue has room; each byte is parsed in the cycle it is taken and its
// results (up to six screen bytes, modem bytes or screen events) go into a
// QUEUE_DEPTH-entry queue. The back end sends one result per cycle on out_if
// while out_if is ready; the first result of an item passes from the queue
// entry through the back end's list register into its output register. Bytes
// that cause no result are not queued. The mode fields on out_if show the
// modes after the whole item. compat_x3 is written through cfg_if, which is
// always ready and must only be written while no result is pending.
module videotex_protocol_command_handler #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic       clk_i,
  input logic       rst_ni,
  vtx_in_if.sink    in_if,
  vtx_out_if.source out_if,
  vtx_cfg_if.sink   cfg_if
);

  logic          compat_x3_q;
  logic          in_fire;
  logic          push, full, pop, job_valid;
  vtx_pkg::job_t job_w, job_r;

  // Configuration register.
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compat_x3_q <= 1'b0;
    end else if (cfg_if.valid) begin
      compat_x3_q <= cfg_if.compat_x3;
    end
  end

  // Input transfer while the queue has room.
  assign in_if.ready = !full;
  assign in_fire     = in_if.valid && !full;

  vtx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .compat_x3_i  (compat_x3_q),
    .in_fire_i    (in_fire),
    .cmd_i        (in_if.cmd),
    .rx_byte_i    (in_if.rx_byte),
    .cursor_row_i (in_if.cursor_row),
    .cursor_col_i (in_if.cursor_col),
    .job_o        (job_w),
    .push_o       (push)
  );

  vtx_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_w),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .rdata_o (job_r)
  );

  vtx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_r),
    .pop_o       (pop),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .channel_o   (out_if.channel),
    .data_o      (out_if.data),
    .kbd_o       (out_if.keyboard_mode),
    .wide_o      (out_if.wide_screen),
    .roll_o      (out_if.roll_on),
    .last_o      (out_if.last)
  );

endmodule

FILE: src/vtx_checker.sv
// Port-level checks of the videotex command handler, bound to its top level.
// Depends on videotex_protocol_command_handler and vtx_pkg.
module vtx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] channel_i,
  input logic [7:0] data_i,
  input logic [2:0] kbd_i,
  input logic       wide_i,
  input logic       roll_i,
  input logic       last_i
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(data_i) && $stable(channel_i))
    else $error("stalled result changed");

  // Results of one item follow each other without a gap and share the modes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=>
      out_valid_i && $stable(kbd_i) && $stable(wide_i) && $stable(roll_i))
    else $error("result list of one item broken");

  // The US keyboard modes are in force exactly when 80-column mode is.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (wide_i == (kbd_i == vtx_pkg::KbMixUs || kbd_i == vtx_pkg::KbInfoUs)))
    else $error("keyboard mode disagrees with column mode");

endmodule

bind videotex_protocol_command_handler vtx_checker u_vtx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .channel_i   (out_if.channel),
  .data_i      (out_if.data),
  .kbd_i       (out_if.keyboard_mode),
  .wide_i      (out_if.wide_screen),
  .roll_i      (out_if.roll_on),
  .last_i      (out_if.last)
);
